FILE: sv/ihl_pkg.sv
// shared types, codes and the hex digit decoder for the hex record loader
// no dependencies

package ihl_pkg;

   localparam logic [2:0] PH_WAIT  = 3'd0;
   localparam logic [2:0] PH_COUNT = 3'd1;
   localparam logic [2:0] PH_ADDR  = 3'd2;
   localparam logic [2:0] PH_TYPE  = 3'd3;
   localparam logic [2:0] PH_DATA  = 3'd4;
   localparam logic [2:0] PH_CSUM  = 3'd5;

   localparam logic [1:0] KIND_WRITE = 2'd0;
   localparam logic [1:0] KIND_END   = 2'd1;
   localparam logic [1:0] KIND_BAD   = 2'd2;

   localparam logic [7:0] TYPE_DATA = 8'h00;
   localparam logic [7:0] TYPE_EOF  = 8'h01;
   localparam logic [7:0] CHAR_COLON = 8'h3a;

   typedef struct packed {
      logic        valid;
      logic [1:0]  kind;
      logic [15:0] address;
      logic [7:0]  data;
   } result_type;

   typedef struct packed {
      logic       finished;
      logic [2:0] phase;
   } status_type;

   // {is_hex, value}
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] r;
      r = 5'b0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b1, 4'(c - 8'h37)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b1, 4'(c - 8'h57)};
      end
      return r;
   endfunction

endpackage

FILE: sv/ihl_decoder.sv
// record decoder: parse state and the result of one character
// depends on ihl_pkg

module ihl_decoder (
   input  logic                clock,
   input  logic                reset,
   input  logic                take,
   input  logic [7:0]          character,
   output ihl_pkg::result_type result,
   output ihl_pkg::status_type status
);

   logic [2:0]  phase_ff, phase_in;
   logic        lnp_ff, lnp_in;
   logic [3:0]  high_ff, high_in;
   logic        fbi_ff, fbi_in;
   logic [7:0]  left_ff, left_in;
   logic [15:0] addr_ff, addr_in;
   logic [7:0]  type_ff, type_in;
   logic        fin_ff, fin_in;

   logic [4:0]  digit;
   logic [7:0]  pair;
   logic        in_record;

   assign digit     = ihl_pkg::hex_digit(character);
   assign pair      = {high_ff, digit[3:0]};
   assign in_record = (phase_ff >= ihl_pkg::PH_COUNT) && (phase_ff <= ihl_pkg::PH_CSUM);

   always_comb begin
      phase_in = phase_ff;
      lnp_in   = lnp_ff;
      high_in  = high_ff;
      fbi_in   = fbi_ff;
      left_in  = left_ff;
      addr_in  = addr_ff;
      type_in  = type_ff;
      fin_in   = fin_ff;
      result   = '0;
      if (take && !fin_ff) begin
         if (!in_record) begin
            phase_in = ihl_pkg::PH_WAIT;
            if (character == ihl_pkg::CHAR_COLON) begin
               phase_in = ihl_pkg::PH_COUNT;
               lnp_in   = 1'b0;
               high_in  = 4'd0;
               fbi_in   = 1'b0;
            end
         end else if (!digit[4]) begin
            phase_in = ihl_pkg::PH_WAIT;
            lnp_in   = 1'b0;
            fbi_in   = 1'b0;
            if (character == ihl_pkg::CHAR_COLON) begin
               phase_in = ihl_pkg::PH_COUNT;
               high_in  = 4'd0;
            end
            result.valid = 1'b1;
            result.kind  = ihl_pkg::KIND_BAD;
         end else if (!lnp_ff) begin
            high_in = digit[3:0];
            lnp_in  = 1'b1;
         end else begin
            lnp_in = 1'b0;
            unique case (phase_ff)
               ihl_pkg::PH_COUNT: begin
                  left_in  = pair;
                  fbi_in   = 1'b0;
                  phase_in = ihl_pkg::PH_ADDR;
               end
               ihl_pkg::PH_ADDR: begin
                  if (!fbi_ff) begin
                     addr_in = {pair, addr_ff[7:0]};
                     fbi_in  = 1'b1;
                  end else begin
                     addr_in  = {addr_ff[15:8], pair};
                     fbi_in   = 1'b0;
                     phase_in = ihl_pkg::PH_TYPE;
                  end
               end
               ihl_pkg::PH_TYPE: begin
                  type_in = pair;
                  if (pair == ihl_pkg::TYPE_DATA) begin
                     phase_in = (left_ff == 8'd0) ? ihl_pkg::PH_CSUM : ihl_pkg::PH_DATA;
                  end else if (pair == ihl_pkg::TYPE_EOF) begin
                     fin_in       = 1'b1;
                     phase_in     = ihl_pkg::PH_WAIT;
                     result.valid = 1'b1;
                     result.kind  = ihl_pkg::KIND_END;
                  end else begin
                     phase_in = ihl_pkg::PH_WAIT;
                  end
               end
               ihl_pkg::PH_DATA: begin
                  addr_in = addr_ff + 16'd1;
                  left_in = left_ff - 8'd1;
                  if (left_ff == 8'd1) begin
                     phase_in = ihl_pkg::PH_CSUM;
                  end
                  result.valid   = 1'b1;
                  result.kind    = ihl_pkg::KIND_WRITE;
                  result.address = addr_ff;
                  result.data    = pair;
               end
               default: begin
                  phase_in = ihl_pkg::PH_WAIT;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= ihl_pkg::PH_WAIT;
         lnp_ff   <= 1'b0;
         high_ff  <= 4'd0;
         fbi_ff   <= 1'b0;
         left_ff  <= 8'd0;
         addr_ff  <= 16'd0;
         type_ff  <= 8'd0;
         fin_ff   <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         lnp_ff   <= lnp_in;
         high_ff  <= high_in;
         fbi_ff   <= fbi_in;
         left_ff  <= left_in;
         addr_ff  <= addr_in;
         type_ff  <= type_in;
         fin_ff   <= fin_in;
      end
   end

   assign status.finished = fin_ff | (type_ff == ihl_pkg::TYPE_EOF & fin_ff);
   assign status.phase    = phase_ff;

endmodule

FILE: sv/intel_hex_record_loader_top.sv
// a decoded result is registered in the output register (or in the skid register while the
// output is stalled) before it appears on rsp_; throughput: one character per cycle while
// req_stall is low, set by the combinational decoder and the two-entry output buffer
// reset: synchronous, active high; clears parse state and the end-of-file flag, empties
// the output buffer
// top level of the hex record loader; depends on ihl_pkg and ihl_decoder

module intel_hex_record_loader_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_character,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [15:0] rsp_address,
   output logic [7:0]  rsp_data
);

   ihl_pkg::result_type res;
   ihl_pkg::status_type status;
   ihl_pkg::result_type out_ff;
   ihl_pkg::result_type skid_ff;
   logic                out_valid_ff;
   logic                skid_valid_ff;
   logic                take;
   logic                out_take;

   assign req_stall = skid_valid_ff;
   assign take      = req_valid && !skid_valid_ff;
   assign out_take  = out_valid_ff && !rsp_stall;

   ihl_decoder u_decoder (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .character (req_character),
      .result    (res),
      .status    (status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (out_take) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (res.valid) begin
         if (!out_valid_ff || out_take) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (out_take) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (out_take) begin
            out_ff <= skid_ff;
         end
      end else if (res.valid) begin
         if (!out_valid_ff || out_take) begin
            out_ff <= res;
         end else begin
            skid_ff <= res;
         end
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_kind    = out_ff.kind;
   assign rsp_address = out_ff.address;
   assign rsp_data    = out_ff.data;

`ifndef SYNTHESIS
   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register holds a result while the output register is empty");

   a_no_result_after_end: assert property (@(posedge clock) disable iff (reset)
      status.finished |-> !res.valid)
      else $error("result produced after the end of file record");

   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_kind == ihl_pkg::KIND_WRITE || rsp_kind == ihl_pkg::KIND_END
                     || rsp_kind == ihl_pkg::KIND_BAD))
      else $error("illegal result kind");

   a_end_enters_wait: assert property (@(posedge clock) disable iff (reset)
      (res.valid && res.kind == ihl_pkg::KIND_END) |=> status.phase == ihl_pkg::PH_WAIT)
      else $error("end of file record did not return the parser to waiting");
`endif

endmodule
